FILE: sv/gaps_pkg.sv
package gaps_pkg;

  localparam int ROW_W      = 6;
  localparam int COL_W      = 6;
  localparam int CELL_W     = ROW_W + COL_W;
  localparam int GRID_ROWS  = 1 << ROW_W;
  localparam int GRID_COLS  = 1 << COL_W;
  localparam int NCELLS     = GRID_ROWS * GRID_COLS;
  localparam int G_W        = 13;
  localparam int H_W        = 7;
  localparam int SEQ_W      = 14;
  localparam int LEN_W      = 12;
  localparam int IDX_W      = 12;
  localparam int OPEN_DEPTH = 8192;
  localparam int HIDX_W     = 13;
  localparam int HCNT_W     = HIDX_W + 1;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_SEARCH = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RDP, S_CLR, S_SEED, S_SEEDW, S_POP, S_POPW, S_CHK,
    S_NB, S_NBW, S_NBC, S_NBP, S_TR, S_TRW, S_FIN
  } top_state_e;

  typedef enum logic [2:0] {
    H_IDLE, H_UP, H_UPC, H_TOP, H_LAST, H_DN, H_DNL, H_DNR
  } heap_state_e;

  typedef struct packed {
    logic [G_W-1:0]    f;
    logic [G_W-1:0]    g;
    logic [SEQ_W-1:0]  seq;
    logic [CELL_W-1:0] loc;
  } heap_entry_t;

  typedef struct packed {
    logic              clear;
    logic              push;
    logic              pop;
    logic [G_W-1:0]    f;
    logic [G_W-1:0]    g;
    logic [CELL_W-1:0] loc;
  } heap_req_t;

  typedef struct packed {
    logic              done;
    logic              empty;
    logic              overflow;
    logic [G_W-1:0]    g;
    logic [CELL_W-1:0] loc;
  } heap_rsp_t;

  function automatic logic precedes(heap_entry_t a, heap_entry_t b);
    if (a.f != b.f) return a.f < b.f;
    return a.seq < b.seq;
  endfunction

  function automatic logic [H_W-1:0] manh(logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                                          logic [ROW_W-1:0] gr, logic [COL_W-1:0] gc);
    logic [ROW_W-1:0] dr;
    logic [COL_W-1:0] dc;
    dr = (r > gr) ? r - gr : gr - r;
    dc = (c > gc) ? c - gc : gc - c;
    return H_W'(dr) + H_W'(dc);
  endfunction

endpackage

FILE: sv/grid_astar_path_search.sv
// Grid A* path search, 64 x 64 cells, 4-neighbour moves, Manhattan heuristic.
// Input channel in_valid_i / in_ready_o carries one command per transfer:
//   opcode 0 writes one map cell, 1 runs a search start -> goal,
//   2 reads one stored path step, 3 only returns status.
// Output channel out_valid_o / out_ready_i returns exactly one result per
// command: found, path length, step row/column (zero unless a valid read),
// and the open list overflow flag of the last search.
// One command at a time; in_ready_o is low while a command is in progress.
// Map write and status: result in the output register the cycle after the transfer.
// Path read: result registered after the path memory read in S_RDP.
// Search: best-cost clearing sweep over all 4096 cells, then per expanded
//   cell a pop with a heap sift-down (states H_DN, H_DNL, H_DNR per
//   level) and a sift-up for each of up to four pushes (H_UP, H_UPC per level),
//   13 levels max; the single-port open-list heap memory sets the pace.
// Reset: the map is swept to all blocked, cell by cell; no command is
// taken until the sweep ends. A stalled result holds in the output register
// and the next command is taken in the cycle that result transfers.
module grid_astar_path_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [5:0]  cell_x_i,
  input  logic [5:0]  cell_y_i,
  input  logic        walkable_i,
  input  logic [5:0]  start_x_i,
  input  logic [5:0]  start_y_i,
  input  logic [5:0]  goal_x_i,
  input  logic [5:0]  goal_y_i,
  input  logic [11:0] step_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        found_o,
  output logic [11:0] path_length_o,
  output logic [5:0]  step_x_o,
  output logic [5:0]  step_y_o,
  output logic        open_overflow_o
);

  localparam int CW = gaps_pkg::CELL_W;
  localparam int RW = gaps_pkg::ROW_W;
  localparam int KW = gaps_pkg::COL_W;
  localparam int GW = gaps_pkg::G_W;

  gaps_pkg::top_state_e state_q, state_d;
  gaps_pkg::heap_req_t  hreq;
  gaps_pkg::heap_rsp_t  hrsp;

  logic [CW-1:0] cnt_q, cell_q, n_q, cur_q, start_q;
  logic [RW-1:0] goal_r_q;
  logic [KW-1:0] goal_c_q;
  logic [GW-1:0] g_q, k_q, len_q;
  logic [1:0]    d_q;
  logic          found_q;
  logic [gaps_pkg::IDX_W-1:0] idx_q;

  logic          out_valid_q, out_found_q, out_ovf_q;
  logic [gaps_pkg::LEN_W-1:0] out_len_q;
  logic [RW-1:0] out_sx_q;
  logic [KW-1:0] out_sy_q;

  logic          accept, out_xfer, out_set, out_valid_d;
  logic          walk_we, walk_wd, walk_rd;
  logic [CW-1:0] walk_addr;
  logic          cost_we;
  logic [CW-1:0] cost_addr;
  logic [GW:0]   cost_wd, cost_rd;
  logic          pred_we;
  logic [CW-1:0] pred_addr;
  logic [1:0]    pred_rd;
  logic          path_we;
  logic [CW-1:0] path_addr, path_rd;

  logic [RW-1:0] cr, ar;
  logic [KW-1:0] cc, ac;
  logic          nb_ok, prv_ok, improve;
  logic [RW-1:0] nr, pr;
  logic [KW-1:0] nc, pc;
  logic [GW-1:0] ng;
  logic [gaps_pkg::LEN_W-1:0] len_sat;

  gaps_ram #(.WIDTH(1), .DEPTH(gaps_pkg::NCELLS)) u_walk (
    .clk_i(clk_i), .we_i(walk_we), .addr_i(walk_addr), .wdata_i(walk_wd), .rdata_o(walk_rd)
  );
  gaps_ram #(.WIDTH(GW + 1), .DEPTH(gaps_pkg::NCELLS)) u_cost (
    .clk_i(clk_i), .we_i(cost_we), .addr_i(cost_addr), .wdata_i(cost_wd), .rdata_o(cost_rd)
  );
  gaps_ram #(.WIDTH(2), .DEPTH(gaps_pkg::NCELLS)) u_pred (
    .clk_i(clk_i), .we_i(pred_we), .addr_i(pred_addr), .wdata_i(d_q), .rdata_o(pred_rd)
  );
  gaps_ram #(.WIDTH(CW), .DEPTH(gaps_pkg::NCELLS)) u_path (
    .clk_i(clk_i), .we_i(path_we), .addr_i(path_addr), .wdata_i(cur_q), .rdata_o(path_rd)
  );

  gaps_heap u_heap (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(hreq), .rsp_o(hrsp));

  assign in_ready_o = (state_q == gaps_pkg::S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign out_xfer   = out_valid_q && out_ready_i;
  assign out_set    = (accept && gaps_pkg::op_e'(opcode_i) != gaps_pkg::OP_SEARCH &&
                       gaps_pkg::op_e'(opcode_i) != gaps_pkg::OP_READ) ||
                      state_q == gaps_pkg::S_RDP || state_q == gaps_pkg::S_FIN;
  assign out_valid_d = out_set || (out_valid_q && !out_xfer);

  assign cr = cell_q[CW-1:KW];
  assign cc = cell_q[KW-1:0];
  assign ar = cur_q[CW-1:KW];
  assign ac = cur_q[KW-1:0];
  assign ng = g_q + 1'b1;
  assign improve = !cost_rd[GW] || (ng < cost_rd[GW-1:0]);
  assign len_sat = len_q[GW-1] ? '1 : len_q[gaps_pkg::LEN_W-1:0];

  // neighbor order: col+1, row+1, col-1, row-1
  always_comb begin
    nr = cr;
    nc = cc;
    nb_ok = 1'b1;
    unique case (d_q)
      2'd0: begin nc = cc + 1'b1; nb_ok = cc != '1; end
      2'd1: begin nr = cr + 1'b1; nb_ok = cr != '1; end
      2'd2: begin nc = cc - 1'b1; nb_ok = cc != '0; end
      default: begin nr = cr - 1'b1; nb_ok = cr != '0; end
    endcase
  end

  always_comb begin
    pr = ar;
    pc = ac;
    prv_ok = 1'b1;
    unique case (pred_rd)
      2'd0: begin pc = ac - 1'b1; prv_ok = ac != '0; end
      2'd1: begin pr = ar - 1'b1; prv_ok = ar != '0; end
      2'd2: begin pc = ac + 1'b1; prv_ok = ac != '1; end
      default: begin pr = ar + 1'b1; prv_ok = ar != '1; end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gaps_pkg::S_INIT: if (cnt_q == '1) state_d = gaps_pkg::S_IDLE;
      gaps_pkg::S_IDLE: begin
        if (accept) begin
          case (gaps_pkg::op_e'(opcode_i))
            gaps_pkg::OP_SEARCH: state_d = gaps_pkg::S_CLR;
            gaps_pkg::OP_READ:   state_d = gaps_pkg::S_RDP;
            default:             state_d = gaps_pkg::S_IDLE;
          endcase
        end
      end
      gaps_pkg::S_RDP:   state_d = gaps_pkg::S_IDLE;
      gaps_pkg::S_CLR:   if (cnt_q == '1) state_d = gaps_pkg::S_SEED;
      gaps_pkg::S_SEED:  state_d = gaps_pkg::S_SEEDW;
      gaps_pkg::S_SEEDW: if (hrsp.done) state_d = gaps_pkg::S_POP;
      gaps_pkg::S_POP:   state_d = hrsp.empty ? gaps_pkg::S_FIN : gaps_pkg::S_POPW;
      gaps_pkg::S_POPW:  if (hrsp.done) state_d = gaps_pkg::S_CHK;
      gaps_pkg::S_CHK: begin
        if (g_q != cost_rd[GW-1:0]) state_d = gaps_pkg::S_POP;
        else if (cell_q == {goal_r_q, goal_c_q}) state_d = gaps_pkg::S_TR;
        else state_d = gaps_pkg::S_NB;
      end
      gaps_pkg::S_NB: begin
        if (nb_ok) state_d = gaps_pkg::S_NBW;
        else if (d_q == 2'd3) state_d = gaps_pkg::S_POP;
      end
      gaps_pkg::S_NBW: begin
        if (walk_rd) state_d = gaps_pkg::S_NBC;
        else state_d = (d_q == 2'd3) ? gaps_pkg::S_POP : gaps_pkg::S_NB;
      end
      gaps_pkg::S_NBC: begin
        if (improve) state_d = gaps_pkg::S_NBP;
        else state_d = (d_q == 2'd3) ? gaps_pkg::S_POP : gaps_pkg::S_NB;
      end
      gaps_pkg::S_NBP: begin
        if (hrsp.done) state_d = (d_q == 2'd3) ? gaps_pkg::S_POP : gaps_pkg::S_NB;
      end
      gaps_pkg::S_TR:  state_d = (k_q == '0) ? gaps_pkg::S_FIN : gaps_pkg::S_TRW;
      gaps_pkg::S_TRW: state_d = prv_ok ? gaps_pkg::S_TR : gaps_pkg::S_FIN;
      gaps_pkg::S_FIN: state_d = gaps_pkg::S_IDLE;
      default:         state_d = gaps_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    walk_we   = 1'b0;
    walk_wd   = 1'b0;
    walk_addr = {cell_x_i, cell_y_i};
    cost_we   = 1'b0;
    cost_addr = cnt_q;
    cost_wd   = '0;
    pred_we   = 1'b0;
    pred_addr = cur_q;
    path_we   = 1'b0;
    path_addr = step_index_i;
    hreq      = '{clear: 1'b0, push: 1'b0, pop: 1'b0,
                  f: GW'(gaps_pkg::manh(start_q[CW-1:KW], start_q[KW-1:0],
                                        goal_r_q, goal_c_q)),
                  g: '0, loc: start_q};
    unique case (state_q)
      gaps_pkg::S_INIT: begin
        walk_we   = 1'b1;
        walk_addr = cnt_q;
      end
      gaps_pkg::S_IDLE: begin
        walk_we    = accept && (gaps_pkg::op_e'(opcode_i) == gaps_pkg::OP_WRITE);
        walk_wd    = walkable_i;
        hreq.clear = accept && (gaps_pkg::op_e'(opcode_i) == gaps_pkg::OP_SEARCH);
      end
      gaps_pkg::S_CLR: cost_we = 1'b1;
      gaps_pkg::S_SEED: begin
        cost_we   = 1'b1;
        cost_addr = start_q;
        cost_wd   = {1'b1, {GW{1'b0}}};
        hreq.push = 1'b1;
      end
      gaps_pkg::S_POP:  hreq.pop = !hrsp.empty;
      gaps_pkg::S_POPW: cost_addr = hrsp.loc;
      gaps_pkg::S_NB:   walk_addr = {nr, nc};
      gaps_pkg::S_NBW:  cost_addr = n_q;
      gaps_pkg::S_NBC: begin
        cost_addr = n_q;
        pred_addr = n_q;
        cost_we   = improve;
        pred_we   = improve;
        cost_wd   = {1'b1, ng};
        hreq.push = improve;
        hreq.f    = ng + GW'(gaps_pkg::manh(n_q[CW-1:KW], n_q[KW-1:0], goal_r_q, goal_c_q));
        hreq.g    = ng;
        hreq.loc  = n_q;
      end
      gaps_pkg::S_TR: pred_addr = cur_q;
      gaps_pkg::S_TRW: begin
        path_we   = 1'b1;
        path_addr = CW'(k_q - 1'b1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gaps_pkg::S_INIT;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      unique case (state_q)
        gaps_pkg::S_INIT: cnt_q <= cnt_q + 1'b1;
        gaps_pkg::S_IDLE: begin
          if (accept) begin
            case (gaps_pkg::op_e'(opcode_i))
              gaps_pkg::OP_SEARCH: begin
                found_q <= 1'b0;
                len_q   <= '0;
                cnt_q   <= '0;
              end
              default: ;
            endcase
          end
        end
        gaps_pkg::S_CLR: cnt_q <= cnt_q + 1'b1;
        gaps_pkg::S_CHK: begin
          if (g_q == cost_rd[GW-1:0] && cell_q == {goal_r_q, goal_c_q}) begin
            found_q <= 1'b1;
            len_q   <= g_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      gaps_pkg::S_IDLE: begin
        if (accept) begin
          start_q  <= {start_x_i, start_y_i};
          goal_r_q <= goal_x_i;
          goal_c_q <= goal_y_i;
          idx_q    <= step_index_i;
          out_found_q <= found_q;
          out_len_q   <= len_sat;
          out_ovf_q   <= hrsp.overflow;
          out_sx_q    <= '0;
          out_sy_q    <= '0;
        end
      end
      gaps_pkg::S_RDP: begin
        if ({1'b0, idx_q} < len_q) begin
          out_sx_q <= path_rd[CW-1:KW];
          out_sy_q <= path_rd[KW-1:0];
        end
      end
      gaps_pkg::S_POPW: begin
        g_q    <= hrsp.g;
        cell_q <= hrsp.loc;
      end
      gaps_pkg::S_CHK: begin
        d_q   <= 2'd0;
        k_q   <= g_q;
        cur_q <= cell_q;
      end
      gaps_pkg::S_NB: begin
        n_q <= {nr, nc};
        if (!nb_ok) d_q <= d_q + 1'b1;
      end
      gaps_pkg::S_NBW: if (!walk_rd) d_q <= d_q + 1'b1;
      gaps_pkg::S_NBC: if (!improve) d_q <= d_q + 1'b1;
      gaps_pkg::S_NBP: if (hrsp.done) d_q <= d_q + 1'b1;
      gaps_pkg::S_TRW: begin
        cur_q <= {pr, pc};
        k_q   <= k_q - 1'b1;
      end
      gaps_pkg::S_FIN: begin
        out_found_q <= found_q;
        out_len_q   <= len_sat;
        out_ovf_q   <= hrsp.overflow;
        out_sx_q    <= '0;
        out_sy_q    <= '0;
      end
      default: ;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = out_found_q;
  assign path_length_o   = out_len_q;
  assign step_x_o        = out_sx_q;
  assign step_y_o        = out_sy_q;
  assign open_overflow_o = out_ovf_q;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == gaps_pkg::S_IDLE) else $error("ready outside idle");
  a_search_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && opcode_i == gaps_pkg::OP_SEARCH |=> state_q == gaps_pkg::S_CLR)
    else $error("search did not start clearing");
  a_found_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !found_q |-> len_q == '0) else $error("length set without found");
`endif

endmodule

FILE: sv/gaps_ram.sv
module gaps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/gaps_heap.sv
module gaps_heap (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gaps_pkg::heap_req_t req_i,
  output gaps_pkg::heap_rsp_t rsp_o
);

  gaps_pkg::heap_state_e state_q, state_d;
  logic [gaps_pkg::HCNT_W-1:0] cnt_q, i_q;
  logic [gaps_pkg::SEQ_W-1:0]  seq_q;
  logic                        ovf_q, done_q, done_d;
  gaps_pkg::heap_entry_t       x_q, cl_q, rd;
  logic [gaps_pkg::G_W-1:0]    g_q;
  logic [gaps_pkg::CELL_W-1:0] cell_q;
  logic                        we;
  logic [gaps_pkg::HIDX_W-1:0] addr;
  gaps_pkg::heap_entry_t       wdata;
  logic [gaps_pkg::HCNT_W:0]   l_idx, r_idx;
  logic [gaps_pkg::HCNT_W-1:0] p_idx;
  logic                        full, up_swap, l_best, r_best;
  gaps_pkg::heap_entry_t       lr_best;

  gaps_ram #(.WIDTH($bits(gaps_pkg::heap_entry_t)), .DEPTH(gaps_pkg::OPEN_DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rd)
  );

  assign l_idx   = {i_q, 1'b1};
  assign r_idx   = l_idx + 1'b1;
  assign p_idx   = (i_q - 1'b1) >> 1;
  assign full    = cnt_q == gaps_pkg::HCNT_W'(gaps_pkg::OPEN_DEPTH);
  assign up_swap = gaps_pkg::precedes(x_q, rd);
  assign l_best  = gaps_pkg::precedes(cl_q, x_q);
  assign lr_best = l_best ? cl_q : x_q;
  assign r_best  = gaps_pkg::precedes(rd, lr_best);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gaps_pkg::H_IDLE: begin
        if (req_i.push && !full) state_d = gaps_pkg::H_UP;
        else if (req_i.pop) state_d = gaps_pkg::H_TOP;
      end
      gaps_pkg::H_UP:  state_d = (i_q == '0) ? gaps_pkg::H_IDLE : gaps_pkg::H_UPC;
      gaps_pkg::H_UPC: state_d = up_swap ? gaps_pkg::H_UP : gaps_pkg::H_IDLE;
      gaps_pkg::H_TOP: state_d = (cnt_q == 1) ? gaps_pkg::H_IDLE : gaps_pkg::H_LAST;
      gaps_pkg::H_LAST: state_d = gaps_pkg::H_DN;
      gaps_pkg::H_DN: begin
        state_d = (l_idx >= {1'b0, cnt_q}) ? gaps_pkg::H_IDLE : gaps_pkg::H_DNL;
      end
      gaps_pkg::H_DNL: begin
        if (r_idx < {1'b0, cnt_q}) state_d = gaps_pkg::H_DNR;
        else state_d = gaps_pkg::precedes(rd, x_q) ? gaps_pkg::H_DN : gaps_pkg::H_IDLE;
      end
      gaps_pkg::H_DNR: state_d = (r_best || l_best) ? gaps_pkg::H_DN : gaps_pkg::H_IDLE;
      default: state_d = gaps_pkg::H_IDLE;
    endcase
  end

  always_comb begin
    we     = 1'b0;
    addr   = '0;
    wdata  = x_q;
    done_d = 1'b0;
    unique case (state_q)
      gaps_pkg::H_IDLE: begin
        if (req_i.push && full) done_d = 1'b1;
      end
      gaps_pkg::H_UP: begin
        if (i_q == '0) begin
          we     = 1'b1;
          done_d = 1'b1;
        end else begin
          addr = p_idx[gaps_pkg::HIDX_W-1:0];
        end
      end
      gaps_pkg::H_UPC: begin
        we   = 1'b1;
        addr = i_q[gaps_pkg::HIDX_W-1:0];
        if (up_swap) wdata = rd;
        else done_d = 1'b1;
      end
      gaps_pkg::H_TOP: begin
        if (cnt_q == 1) done_d = 1'b1;
        else addr = gaps_pkg::HIDX_W'(cnt_q - 1'b1);
      end
      gaps_pkg::H_LAST: ;
      gaps_pkg::H_DN: begin
        if (l_idx >= {1'b0, cnt_q}) begin
          we     = 1'b1;
          addr   = i_q[gaps_pkg::HIDX_W-1:0];
          done_d = 1'b1;
        end else begin
          addr = l_idx[gaps_pkg::HIDX_W-1:0];
        end
      end
      gaps_pkg::H_DNL: begin
        if (r_idx < {1'b0, cnt_q}) begin
          addr = r_idx[gaps_pkg::HIDX_W-1:0];
        end else begin
          we   = 1'b1;
          addr = i_q[gaps_pkg::HIDX_W-1:0];
          if (gaps_pkg::precedes(rd, x_q)) wdata = rd;
          else done_d = 1'b1;
        end
      end
      gaps_pkg::H_DNR: begin
        we   = 1'b1;
        addr = i_q[gaps_pkg::HIDX_W-1:0];
        if (r_best) wdata = rd;
        else if (l_best) wdata = cl_q;
        else done_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gaps_pkg::H_IDLE;
      cnt_q   <= '0;
      seq_q   <= '0;
      ovf_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (state_q == gaps_pkg::H_IDLE) begin
        if (req_i.clear) begin
          cnt_q <= '0;
          seq_q <= '0;
          ovf_q <= 1'b0;
        end else if (req_i.push) begin
          if (full) begin
            ovf_q <= 1'b1;
          end else begin
            cnt_q <= cnt_q + 1'b1;
            seq_q <= seq_q + 1'b1;
          end
        end
      end
      if (state_q == gaps_pkg::H_TOP) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      gaps_pkg::H_IDLE: begin
        x_q <= '{f: req_i.f, g: req_i.g, seq: seq_q, loc: req_i.loc};
        i_q <= cnt_q;
      end
      gaps_pkg::H_UPC: if (up_swap) i_q <= p_idx;
      gaps_pkg::H_TOP: begin
        g_q    <= rd.g;
        cell_q <= rd.loc;
      end
      gaps_pkg::H_LAST: begin
        x_q <= rd;
        i_q <= '0;
      end
      gaps_pkg::H_DNL: begin
        cl_q <= rd;
        if (!(r_idx < {1'b0, cnt_q}) && gaps_pkg::precedes(rd, x_q))
          i_q <= l_idx[gaps_pkg::HCNT_W-1:0];
      end
      gaps_pkg::H_DNR: begin
        if (r_best) i_q <= r_idx[gaps_pkg::HCNT_W-1:0];
        else if (l_best) i_q <= l_idx[gaps_pkg::HCNT_W-1:0];
      end
      default: ;
    endcase
  end

  assign rsp_o = '{done: done_q, empty: cnt_q == '0, overflow: ovf_q, g: g_q, loc: cell_q};

endmodule
